// ----- sv/tmbs_pkg.sv -----
`timescale 1ns / 1ps
// tmbs_pkg: shared constants for the touch matrix baseline scan block.
// No dependencies; imported by touch_matrix_baseline_scan_top.

package tmbs_pkg;

  // default geometry and sample format
  localparam int DEF_COLUMNS          = 10;
  localparam int DEF_ROWS             = 7;
  localparam int DEF_SAMPLES_PER_CELL = 5;
  localparam int DEF_SAMPLE_BITS      = 12;

  // fixed widths of the position fields on the result channel
  localparam int COL_W = 4;
  localparam int ROW_W = 3;

endpackage

// ----- sv/touch_matrix_baseline_scan_top.sv -----
`timescale 1ns / 1ps
// touch_matrix_baseline_scan_top: averages ADC conversions per touch cell and
// subtracts a stored per-cell baseline. Depends on tmbs_pkg.
//
// Usage:
//   in_*  : one ADC conversion per word, in scan order (column outer, row inner),
//           SAMPLES_PER_CELL conversions per cell.
//   out_* : one word per finished cell (column, row, level, frame_end) once the
//           baseline frame is done; out_frame_end marks the last cell of a frame.
//   The first full frame after reset is written into the baseline memory and
//   produces no output words.
// Timing:
//   A new conversion is accepted every cycle (one word per cycle sustained) while
//   in_ready is high. The cell result passes through the divide/subtract stage,
//   whose baseline read is issued at accept time from a memory with a registered
//   read, and then into the output register; a stall at the output can hold the
//   cell in the divide/subtract stage.
// Reset (rst_n low, synchronous): scan position, accumulator and baseline flag
//   clear; the baseline memory itself is not cleared, it is rewritten by the
//   first frame. No clearing pass is needed.
// Stalls: while out_ready is low the output register holds its word; the
//   stage behind it still takes one more cell, then in_ready drops.

module touch_matrix_baseline_scan_top
  import tmbs_pkg::*;
#(
  parameter int COLUMNS          = DEF_COLUMNS,
  parameter int ROWS             = DEF_ROWS,
  parameter int SAMPLES_PER_CELL = DEF_SAMPLES_PER_CELL,
  parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COL_W-1:0]       out_column,
  output logic [ROW_W-1:0]       out_row,
  output logic [SAMPLE_BITS-1:0] out_level,
  output logic                   out_frame_end
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W  = (SAMPLES_PER_CELL > 1) ? $clog2(SAMPLES_PER_CELL) : 1;
  localparam int LOG_N  = $clog2(SAMPLES_PER_CELL);
  localparam int SUM_W  = SAMPLE_BITS + LOG_N;
  // divide by SAMPLES_PER_CELL as multiply by rounded-up reciprocal, exact for SUM_W bits
  localparam int DIV_SH = SUM_W + LOG_N;
  localparam int MUL_W  = SUM_W + 2;
  localparam int PROD_W = SUM_W + MUL_W;
  localparam longint unsigned DIV_MUL_L =
    ((64'd1 << DIV_SH) + SAMPLES_PER_CELL - 1) / SAMPLES_PER_CELL;
  localparam logic [63:0] DIV_MUL_V = DIV_MUL_L;
  localparam logic [MUL_W-1:0] DIV_MUL = DIV_MUL_V[MUL_W-1:0];

  // scan position and accumulator
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [CELL_W-1:0] cell_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  sum_r;
  logic              base_rdy_r;

  // divide/subtract stage
  logic              s1_v_r;
  logic              s1_emit_r;
  logic              s1_last_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [ROW_W-1:0]  s1_row_r;
  logic [CELL_W-1:0] s1_cell_r;
  logic [SUM_W-1:0]  s1_sum_r;
  logic [SAMPLE_BITS-1:0] base_q_r;

  // output register
  logic                   out_v_r;
  logic [COL_W-1:0]       out_col_r;
  logic [ROW_W-1:0]       out_row_r;
  logic [SAMPLE_BITS-1:0] out_lvl_r;
  logic                   out_last_r;

  logic [SAMPLE_BITS-1:0] base_mem [CELLS];

  logic                   acc;
  logic                   cell_done;
  logic                   row_wrap;
  logic                   col_wrap;
  logic                   out_free;
  logic                   s1_go;
  logic                   s1_load;
  logic                   s1_wr;
  logic [SUM_W-1:0]       sum_full;
  logic [PROD_W-1:0]      prod;
  logic [SAMPLE_BITS-1:0] s1_avg;
  logic [SAMPLE_BITS-1:0] s1_level;

  assign out_free  = !out_v_r || out_ready;
  assign s1_go     = s1_v_r && (!s1_emit_r || out_free);
  assign in_ready  = !s1_v_r || s1_go;
  assign acc       = in_valid && in_ready;
  assign cell_done = (cnt_r == CNT_W'(SAMPLES_PER_CELL - 1));
  assign s1_load   = acc && cell_done;
  assign s1_wr     = s1_go && !s1_emit_r;
  assign row_wrap  = (row_r == ROW_W'(ROWS - 1));
  assign col_wrap  = (col_r == COL_W'(COLUMNS - 1));
  assign sum_full  = sum_r + SUM_W'(in_sample);

  always_comb begin
    prod     = PROD_W'(s1_sum_r) * PROD_W'(DIV_MUL);
    s1_avg   = SAMPLE_BITS'(prod >> DIV_SH);
    s1_level = (s1_avg > base_q_r) ? (s1_avg - base_q_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      cell_r     <= '0;
      cnt_r      <= '0;
      sum_r      <= '0;
      base_rdy_r <= 1'b0;
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (acc) begin
        if (cell_done) begin
          cnt_r <= '0;
          sum_r <= '0;
          if (row_wrap) begin
            row_r <= '0;
            if (col_wrap) begin
              col_r      <= '0;
              cell_r     <= '0;
              base_rdy_r <= 1'b1;
            end else begin
              col_r  <= col_r + 1'b1;
              cell_r <= cell_r + 1'b1;
            end
          end else begin
            row_r  <= row_r + 1'b1;
            cell_r <= cell_r + 1'b1;
          end
        end else begin
          cnt_r <= cnt_r + 1'b1;
          sum_r <= sum_full;
        end
      end

      if (s1_load) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end

      if (s1_go && s1_emit_r) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_emit_r <= base_rdy_r;
      s1_last_r <= row_wrap && col_wrap;
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
      s1_cell_r <= cell_r;
      s1_sum_r  <= sum_full;
    end
    if (s1_go && s1_emit_r) begin
      out_col_r  <= s1_col_r;
      out_row_r  <= s1_row_r;
      out_lvl_r  <= s1_level;
      out_last_r <= s1_last_r;
    end
  end

  // baseline memory, write-first on a same-cell read
  always_ff @(posedge clk) begin
    if (s1_wr) begin
      base_mem[s1_cell_r] <= s1_avg;
    end
    if (s1_load) begin
      base_q_r <= (s1_wr && (s1_cell_r == cell_r)) ? s1_avg : base_mem[cell_r];
    end
  end

  assign out_valid     = out_v_r;
  assign out_column    = out_col_r;
  assign out_row       = out_row_r;
  assign out_level     = out_lvl_r;
  assign out_frame_end = out_last_r;

endmodule
